[rtl/core/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the SLIP frame decoder
// Field widths, SLIP code values, the command codes that the front stage
// hands to the back stage, and the queue geometry.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Field widths of the channels and the configuration register.
    localparam int ACTION_W = 1;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 10;
    localparam int LENGTH_W = 11;
    localparam int CFG_W    = 11;

    // Largest frame length that the length field can report.
    localparam int LENGTH_FIELD_MAX = 1024;

    // SLIP code values.
    localparam logic [BYTE_W-1:0] CODE_END     = 8'hC0;
    localparam logic [BYTE_W-1:0] CODE_ESC     = 8'hDB;
    localparam logic [BYTE_W-1:0] CODE_ESC_END = 8'hDC;
    localparam logic [BYTE_W-1:0] CODE_ESC_ESC = 8'hDD;

    // Input action codes.
    localparam logic [ACTION_W-1:0] ACT_BYTE       = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_LINE_ERROR = 1'b1;

    // Result kind codes.
    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified input item.
    typedef enum logic [2:0] {
        OP_DATA,
        OP_END,
        OP_ESC,
        OP_ESC_END,
        OP_ESC_ESC,
        OP_LINE_ERR
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] data;
    } cmd_t;

endpackage

[rtl/core/sfd_if.sv]
// ----------------------------------------------------------------------------
// sfd_rx_if / sfd_res_if: valid/ready channels of the SLIP frame decoder
// The receive channel carries raw bytes and line-error events; the result
// channel carries decoded bytes and frame-end reports.
// ----------------------------------------------------------------------------
interface sfd_rx_if import sfd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface sfd_res_if import sfd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                result_kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [INDEX_W-1:0]  byte_index;
    logic [LENGTH_W-1:0] frame_len;
    logic                frame_drop;

    modport source (output valid, output result_kind, output data_byte,
                    output byte_index, output frame_len, output frame_drop,
                    input ready);
    modport sink   (input valid, input result_kind, input data_byte,
                    input byte_index, input frame_len, input frame_drop,
                    output ready);
endinterface

[rtl/core/slip_frame_decoder.sv]
// ----------------------------------------------------------------------------
// slip_frame_decoder: SLIP byte stream deframer
// Decodes SLIP escapes, numbers payload bytes within a frame and reports
// each frame end with its length and a dropped flag.
// ----------------------------------------------------------------------------
// Usage:
// The rx channel takes one item per transfer: a raw byte (action 0) or a
// line-error event (action 1). The result channel returns either a decoded
// payload byte with its index in the frame, or a frame-end report with the
// decoded length (zero when dropped) and the dropped flag. An item gives at
// most one result; escapes, empty frames and bytes in a dropped frame give
// none.
// The configuration port writes frame_capacity through cfg_we/cfg_wdata;
// the value is clamped to the smaller of BUFFER_DEPTH and 1024.
// Throughput is one item per cycle, set by the state update in the back
// stage, while the receiver does not stall. An rx transfer reaches a valid
// result via the input register, the command queue and the output register.
// Reset clears the frame state, empties the queue and sets the capacity to
// its largest value. When the receiver stalls, the output register holds its
// result, the four-entry queue and the input register fill, and only then
// does rx.ready drop.
// ----------------------------------------------------------------------------
module slip_frame_decoder import sfd_pkg::*; #(
    parameter int BUFFER_DEPTH = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    sfd_rx_if.sink           rx,
    sfd_res_if.source        result
);

    logic front_valid;
    cmd_t front_cmd;
    logic front_ready;
    logic queue_valid;
    cmd_t queue_cmd;
    logic queue_ready;

    // Input stage and classification.
    sfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (front_ready)
    );

    // Command queue.
    sfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_cmd    (front_cmd),
        .in_ready  (front_ready),
        .out_valid (queue_valid),
        .out_cmd   (queue_cmd),
        .out_ready (queue_ready)
    );

    // Frame state and results.
    sfd_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (queue_valid),
        .cmd       (queue_cmd),
        .cmd_ready (queue_ready),
        .result    (result)
    );

endmodule

[rtl/core/sfd_front.sv]
// ----------------------------------------------------------------------------
// sfd_front: input stage of the SLIP frame decoder
// Accepts receive transfers, classifies each one into a command code and
// holds it in a register until the command queue takes it.
// ----------------------------------------------------------------------------
module sfd_front import sfd_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    sfd_rx_if.sink rx,
    output logic  cmd_valid,
    output cmd_t  cmd,
    input  logic  cmd_ready
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic take;

    // The stage takes a new item when empty or when its item leaves now.
    assign rx.ready = !valid_reg || cmd_ready;
    assign take     = rx.valid && rx.ready;

    // Classify the incoming item.
    always_comb
    begin
        cmd_next.data = rx.rx_byte;
        if (rx.action == ACT_LINE_ERROR)
        begin
            cmd_next.op = OP_LINE_ERR;
        end
        else
        begin
            unique case (rx.rx_byte)
                CODE_END:     cmd_next.op = OP_END;
                CODE_ESC:     cmd_next.op = OP_ESC;
                CODE_ESC_END: cmd_next.op = OP_ESC_END;
                CODE_ESC_ESC: cmd_next.op = OP_ESC_ESC;
                default:      cmd_next.op = OP_DATA;
            endcase
        end
    end

    // Stage occupancy.
    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Command payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

[rtl/core/sfd_queue.sv]
// ----------------------------------------------------------------------------
// sfd_queue: command queue between front and back
// A small register FIFO that lets the input side and the result side stall
// independently of each other.
// ----------------------------------------------------------------------------
module sfd_queue import sfd_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  cmd_t in_cmd,
    output logic in_ready,
    output logic out_valid,
    output cmd_t out_cmd,
    input  logic out_ready
);

    cmd_t              store [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = store[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill-level update.
    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        priority if (push && !pop)
        begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[rtl/core/sfd_back.sv]
// ----------------------------------------------------------------------------
// sfd_back: frame state and result stage of the SLIP frame decoder
// Executes one queued command per cycle against the frame state (byte count,
// escape and drop flags) when not stalled; results load the output register.
// ----------------------------------------------------------------------------
module sfd_back import sfd_pkg::*; #(
    parameter int BUFFER_DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              cmd_valid,
    input  cmd_t              cmd,
    output logic              cmd_ready,
    sfd_res_if.source         result
);

    // Hard limit on the capacity: buffer depth and length field range.
    localparam int CAP_LIMIT = (BUFFER_DEPTH < LENGTH_FIELD_MAX) ? BUFFER_DEPTH
                                                                 : LENGTH_FIELD_MAX;
    localparam logic [LENGTH_W-1:0] CAP_LIMIT_W = LENGTH_W'(CAP_LIMIT);

    logic [LENGTH_W-1:0] cap_reg;
    logic [LENGTH_W-1:0] cap_next;
    logic [LENGTH_W-1:0] count_reg;
    logic [LENGTH_W-1:0] count_next;
    logic                esc_reg;
    logic                esc_next;
    logic                drop_reg;
    logic                drop_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                kind_reg;
    logic [BYTE_W-1:0]   data_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [LENGTH_W-1:0] length_reg;
    logic                dropped_reg;

    logic                res_valid;
    logic                res_kind;
    logic [BYTE_W-1:0]   res_data;
    logic [INDEX_W-1:0]  res_index;
    logic [LENGTH_W-1:0] res_length;
    logic                res_dropped;
    logic [BYTE_W-1:0]   decoded;
    logic                emit_byte;
    logic                exec;

    // A command runs whenever the output register can take its result.
    assign cmd_ready = !out_valid_reg || result.ready;
    assign exec      = cmd_valid && cmd_ready;

    // Effective capacity is clamped when written.
    assign cap_next = (cfg_wdata > CAP_LIMIT_W) ? CAP_LIMIT_W : cfg_wdata;

    // Command execution against the frame state.
    always_comb
    begin
        count_next  = count_reg;
        esc_next    = esc_reg;
        drop_next   = drop_reg;
        res_valid   = 1'b0;
        res_kind    = KIND_PAYLOAD;
        res_data    = '0;
        res_index   = '0;
        res_length  = '0;
        res_dropped = 1'b0;
        decoded     = cmd.data;
        emit_byte   = 1'b0;

        unique case (cmd.op)
            OP_LINE_ERR:
            begin
                count_next = '0;
                esc_next   = 1'b0;
                drop_next  = 1'b1;
            end
            OP_END:
            begin
                // A frame end reports unless the frame is empty and clean.
                if (drop_reg)
                begin
                    res_valid   = 1'b1;
                    res_kind    = KIND_FRAME_END;
                    res_dropped = 1'b1;
                end
                else if (count_reg != '0)
                begin
                    res_valid  = 1'b1;
                    res_kind   = KIND_FRAME_END;
                    res_length = count_reg;
                end
                count_next = '0;
                esc_next   = 1'b0;
                drop_next  = 1'b0;
            end
            OP_DATA, OP_ESC, OP_ESC_END, OP_ESC_ESC:
            begin
                if (!drop_reg)
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        if (cmd.op == OP_ESC_END)
                        begin
                            decoded   = CODE_END;
                            emit_byte = 1'b1;
                        end
                        else if (cmd.op == OP_ESC_ESC)
                        begin
                            decoded   = CODE_ESC;
                            emit_byte = 1'b1;
                        end
                        else
                        begin
                            // Bad escape sequence.
                            count_next = '0;
                            drop_next  = 1'b1;
                        end
                    end
                    else if (cmd.op == OP_ESC)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        emit_byte = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // A decoded byte either fits in the frame or overruns it.
        if (emit_byte)
        begin
            if (count_reg < cap_reg)
            begin
                res_valid  = 1'b1;
                res_kind   = KIND_PAYLOAD;
                res_data   = decoded;
                res_index  = count_reg[INDEX_W-1:0];
                count_next = LENGTH_W'(count_reg + 1'b1);
            end
            else
            begin
                count_next = '0;
                esc_next   = 1'b0;
                drop_next  = 1'b1;
            end
        end
    end

    // Output register occupancy.
    always_comb
    begin
        if (exec)
        begin
            out_valid_next = res_valid;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_LIMIT_W;
            count_reg     <= '0;
            esc_reg       <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cap_next;
            end
            if (exec)
            begin
                count_reg <= count_next;
                esc_reg   <= esc_next;
                drop_reg  <= drop_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload is loaded only with a new result.
    always_ff @(posedge clk)
    begin
        if (exec && res_valid)
        begin
            kind_reg    <= res_kind;
            data_reg    <= res_data;
            index_reg   <= res_index;
            length_reg  <= res_length;
            dropped_reg <= res_dropped;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.result_kind = kind_reg;
    assign result.data_byte   = data_reg;
    assign result.byte_index  = index_reg;
    assign result.frame_len   = length_reg;
    assign result.frame_drop  = dropped_reg;

endmodule

[rtl/core/sfd_checker.sv]
// ----------------------------------------------------------------------------
// sfd_checker: port-level assertions of the SLIP frame decoder
// Checks result handshake behavior and field consistency of result kinds.
// ----------------------------------------------------------------------------
module sfd_checker import sfd_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input logic                res_kind,
    input logic [BYTE_W-1:0]   res_data,
    input logic [INDEX_W-1:0]  res_index,
    input logic [LENGTH_W-1:0] res_len,
    input logic                res_drop
);

    // A stalled result stays offered.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped during stall");

    // A stalled result keeps its payload.
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            $stable(res_kind) && $stable(res_data) &&
            $stable(res_index) && $stable(res_len) &&
            $stable(res_drop))
        else $error("result payload changed during stall");

    // A payload byte carries no frame-end information.
    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_PAYLOAD |->
            res_len == '0 && !res_drop)
        else $error("payload result carries frame-end fields");

    // A dropped frame reports zero length.
    a_dropped_length: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_FRAME_END && res_drop |->
            res_len == '0 && res_data == '0 && res_index == '0)
        else $error("dropped frame end with nonzero fields");

    // A clean frame end never reports an empty frame.
    a_clean_length: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_FRAME_END && !res_drop |->
            res_len != '0 && res_len <= LENGTH_W'(LENGTH_FIELD_MAX))
        else $error("clean frame end with bad length");

endmodule

bind slip_frame_decoder sfd_checker u_sfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_kind  (result.result_kind),
    .res_data  (result.data_byte),
    .res_index (result.byte_index),
    .res_len   (result.frame_len),
    .res_drop  (result.frame_drop)
);
